// File: rtl/mcsw_pkg.sv
package mcsw_pkg;

    // request codes of the item channel
    localparam logic [1:0] REQ_TICK      = 2'd0;
    localparam logic [1:0] REQ_HEARTBEAT = 2'd1;
    localparam logic [1:0] REQ_CHECK     = 2'd2;
    localparam logic [1:0] REQ_SAMPLE    = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRACE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TMO_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TMO_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGETS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SIM_MODE  = 3'd6;
    localparam int CFG_DATA_W = 64;

    // register reset values
    localparam logic [15:0] GRACE_RST    = 16'd300;
    localparam logic [15:0] COOLDOWN_RST = 16'd300;
    localparam logic [63:0] TMO_LOW_RST  = 64'd8444378152304690;
    localparam logic [63:0] TMO_HIGH_RST = 64'd3276950;
    localparam logic [23:0] TARGETS_RST  = 24'd149128;
    localparam logic [7:0]  ENABLE_RST   = 8'd63;

    // fixed field widths
    localparam int MAX_CH     = 8;
    localparam int CH_W       = 3;
    localparam int TGT_W      = 3;
    localparam int TMO_W      = 16;
    localparam int TIME_W     = 32;
    localparam int MASK_W     = 8;

    localparam logic [TIME_W-1:0] TIME_MAX    = '1;
    // backward jumps count only from 1 s onwards
    localparam logic [TIME_W-1:0] JUMP_MIN_MS = 32'd1000;

    // controller to datapath
    typedef struct packed {
        logic            load;
        logic            chk_step;
        logic            jmp_step;
        logic            out_load;
        logic [CH_W-1:0] idx;
    } mcsw_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic go_check;
        logic go_jump;
    } mcsw_status_t;

endpackage

// File: rtl/mcsw_if.sv
interface mcsw_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [2:0]  channel;
    logic [31:0] sim_time_ms;
    logic [7:0]  target_present;

    modport source (output valid, req_type, channel, sim_time_ms, target_present,
                    input ready);
    modport sink (input valid, req_type, channel, sim_time_ms, target_present,
                  output ready);
endinterface

interface mcsw_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] kill_mask;
    logic       clock_jump;
    logic       in_grace;

    modport source (output valid, kill_mask, clock_jump, in_grace, input ready);
    modport sink (input valid, kill_mask, clock_jump, in_grace, output ready);
endinterface

// File: rtl/mcsw_datapath.sv
module mcsw_datapath #(
    parameter int NUM_CHANNELS = 8,
    parameter int NUM_TARGETS  = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [mcsw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mcsw_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [1:0]                           req_type,
    input  logic [2:0]                           channel,
    input  logic [31:0]                          sim_time_ms,
    input  logic [7:0]                           target_present,
    input  mcsw_pkg::mcsw_cmd_t                  cmd,
    output mcsw_pkg::mcsw_status_t               status,
    output logic [7:0]                           kill_mask,
    output logic                                 clock_jump,
    output logic                                 in_grace
);
    import mcsw_pkg::*;

    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int TW = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;

    // configuration
    logic [15:0]       grace_reg;
    logic [15:0]       cool_reg;
    logic [63:0]       tmo_lo_reg;
    logic [63:0]       tmo_hi_reg;
    logic [23:0]       tgt_map_reg;
    logic [7:0]        en_reg;
    logic              sim_mode_reg;

    // watchdog state
    logic [TIME_W-1:0] time_reg;
    logic [TIME_W-1:0] seen_reg [NUM_CHANNELS];
    logic [TIME_W-1:0] kill_time_reg [NUM_TARGETS];
    logic [NUM_TARGETS-1:0] kill_vld_reg;
    logic [TIME_W-1:0] sim_last_reg;

    // per-item working registers
    logic [MASK_W-1:0] present_reg;
    logic [MASK_W-1:0] kills_reg;
    logic              jump_reg;

    // result payload
    logic [MASK_W-1:0] kill_mask_reg;
    logic              clock_jump_reg;
    logic              in_grace_reg;

    logic [TMO_W-1:0]  tmo [MAX_CH];
    logic [TGT_W-1:0]  tgt [MAX_CH];

    logic              grace_now;
    logic              jump_cond;
    logic [CW-1:0]     ci;
    logic [TGT_W-1:0]  cur_tgt;
    logic [TW-1:0]     tidx;
    logic              tgt_ok;
    logic              stale;
    logic              cool;
    logic              en_i;
    logic              pres;
    logic              chk_fire;
    logic              jmp_fire;

    // unpack per-channel timeout and target fields
    for (genvar k = 0; k < MAX_CH; k++)
    begin : g_fields
        if (k < 4)
        begin : g_lo
            assign tmo[k] = tmo_lo_reg[TMO_W*k +: TMO_W];
        end
        else
        begin : g_hi
            assign tmo[k] = tmo_hi_reg[TMO_W*(k-4) +: TMO_W];
        end
        assign tgt[k] = tgt_map_reg[TGT_W*k +: TGT_W];
    end

    // grace and clock jump decision for an incoming beat
    assign grace_now = time_reg < {16'd0, grace_reg};
    assign jump_cond = (req_type == REQ_SAMPLE) && sim_mode_reg
                       && (sim_last_reg >= JUMP_MIN_MS)
                       && (sim_time_ms < sim_last_reg) && !grace_now;

    assign status.go_check = (req_type == REQ_CHECK) && !grace_now;
    assign status.go_jump  = jump_cond;

    // channel visited in this step
    assign ci      = cmd.idx[CW-1:0];
    assign cur_tgt = tgt[cmd.idx];
    assign tidx    = cur_tgt[TW-1:0];
    assign tgt_ok  = {1'b0, cur_tgt} < 4'(NUM_TARGETS);
    assign en_i    = en_reg[cmd.idx];
    assign pres    = present_reg[cur_tgt];
    assign stale   = (time_reg - seen_reg[ci]) >= {16'd0, tmo[cmd.idx]};
    assign cool    = tgt_ok && kill_vld_reg[tidx]
                     && ((time_reg - kill_time_reg[tidx]) < {16'd0, cool_reg});

    assign chk_fire = en_i && stale && tgt_ok && !cool && pres;
    assign jmp_fire = en_i && tgt_ok && !kills_reg[cur_tgt] && !cool && pres;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grace_reg    <= GRACE_RST;
            cool_reg     <= COOLDOWN_RST;
            tmo_lo_reg   <= TMO_LOW_RST;
            tmo_hi_reg   <= TMO_HIGH_RST;
            tgt_map_reg  <= TARGETS_RST;
            en_reg       <= ENABLE_RST;
            sim_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRACE:    grace_reg    <= cfg_data[15:0];
                CFG_COOLDOWN: cool_reg     <= cfg_data[15:0];
                CFG_TMO_LOW:  tmo_lo_reg   <= cfg_data;
                CFG_TMO_HIGH: tmo_hi_reg   <= cfg_data;
                CFG_TARGETS:  tgt_map_reg  <= cfg_data[23:0];
                CFG_ENABLE:   en_reg       <= cfg_data[7:0];
                CFG_SIM_MODE: sim_mode_reg <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // watchdog state and per-item work
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg     <= '0;
            sim_last_reg <= '0;
            kill_vld_reg <= '0;
            present_reg  <= '0;
            kills_reg    <= '0;
            jump_reg     <= 1'b0;
            for (int j = 0; j < NUM_CHANNELS; j++)
            begin
                seen_reg[j] <= '0;
            end
            for (int t = 0; t < NUM_TARGETS; t++)
            begin
                kill_time_reg[t] <= '0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                kills_reg   <= '0;
                jump_reg    <= jump_cond;
                present_reg <= target_present;
                case (req_type)
                    REQ_TICK:
                    begin
                        if (time_reg != TIME_MAX)
                        begin
                            time_reg <= time_reg + 32'd1;
                        end
                    end
                    REQ_HEARTBEAT:
                    begin
                        if ({1'b0, channel} < 4'(NUM_CHANNELS))
                        begin
                            seen_reg[channel[CW-1:0]] <= time_reg;
                        end
                    end
                    REQ_CHECK: ;
                    REQ_SAMPLE:
                    begin
                        if (sim_mode_reg)
                        begin
                            sim_last_reg <= sim_time_ms;
                        end
                        // a jump re-stamps every channel
                        if (jump_cond)
                        begin
                            for (int j = 0; j < NUM_CHANNELS; j++)
                            begin
                                seen_reg[j] <= time_reg;
                            end
                        end
                    end
                    default: ;
                endcase
            end

            // stale check: signal target and re-stamp all of its channels
            if (cmd.chk_step && chk_fire)
            begin
                kills_reg[cur_tgt]   <= 1'b1;
                kill_time_reg[tidx]  <= time_reg;
                kill_vld_reg[tidx]   <= 1'b1;
                for (int j = 0; j < NUM_CHANNELS; j++)
                begin
                    if (tgt[j] == cur_tgt)
                    begin
                        seen_reg[j] <= time_reg;
                    end
                end
            end

            // clock jump: signal each eligible target once
            if (cmd.jmp_step && jmp_fire)
            begin
                kills_reg[cur_tgt]  <= 1'b1;
                kill_time_reg[tidx] <= time_reg;
                kill_vld_reg[tidx]  <= 1'b1;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            kill_mask_reg  <= kills_reg;
            clock_jump_reg <= jump_reg;
            in_grace_reg   <= grace_now;
        end
    end

    assign kill_mask  = kill_mask_reg;
    assign clock_jump = clock_jump_reg;
    assign in_grace   = in_grace_reg;

endmodule

// File: rtl/mcsw_ctrl.sv
module mcsw_ctrl #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    output logic                   result_valid,
    input  logic                   result_ready,
    input  mcsw_pkg::mcsw_status_t status,
    output mcsw_pkg::mcsw_cmd_t    cmd
);
    import mcsw_pkg::*;

    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CW-1:0] LAST_IDX = CW'(NUM_CHANNELS - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_JUMP  = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;
    logic          accept;
    logic          slot_free;

    assign item_ready   = (state_reg == S_IDLE);
    assign accept       = item_valid && item_ready;
    assign result_valid = out_valid_reg;
    assign slot_free    = !out_valid_reg || result_ready;

    // sequencing of one item
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !result_ready;
        cmd.load       = 1'b0;
        cmd.chk_step   = 1'b0;
        cmd.jmp_step   = 1'b0;
        cmd.out_load   = 1'b0;
        cmd.idx        = CH_W'(cnt_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    cnt_next = '0;
                    if (status.go_check)
                    begin
                        state_next = S_CHECK;
                    end
                    else if (status.go_jump)
                    begin
                        state_next = S_JUMP;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_CHECK, S_JUMP:
            begin
                cmd.chk_step = (state_reg == S_CHECK);
                cmd.jmp_step = (state_reg == S_JUMP);
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            S_FIN:
            begin
                // wait for the output register to free up
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/multi_channel_stale_watchdog.sv
// channel   dir   beat payload
// item      in    req_type, channel, sim_time_ms, target_present
// result    out   kill_mask, clock_jump, in_grace
// cfg       in    cfg_we, cfg_index, cfg_data (write only)
//
// tick, heartbeat, clock sample and in-grace check items go from accept to the final step
// a check after grace or an acted-on clock jump first visits all NUM_CHANNELS channels: one
// channel is visited per cycle by the controller's index counter
// state resets to zero, the registers to defaults, the result payload not; no clearing pass
// a new item is taken while the previous result still waits; a stalled result
// holds the block in its final step until the output register is free
module multi_channel_stale_watchdog #(
    parameter int NUM_CHANNELS = 8,
    parameter int NUM_TARGETS  = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    mcsw_item_if.sink                       item,
    mcsw_result_if.source                   result,
    input  logic                            cfg_we,
    input  logic [mcsw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mcsw_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mcsw_pkg::*;

    mcsw_cmd_t    cmd;
    mcsw_status_t status;

    // sequencer
    mcsw_ctrl #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    // state, registers and per-channel evaluation
    mcsw_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .NUM_TARGETS  (NUM_TARGETS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req_type       (item.req_type),
        .channel        (item.channel),
        .sim_time_ms    (item.sim_time_ms),
        .target_present (item.target_present),
        .cmd            (cmd),
        .status         (status),
        .kill_mask      (result.kill_mask),
        .clock_jump     (result.clock_jump),
        .in_grace       (result.in_grace)
    );

    // a loaded result shows up as valid next cycle
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> result.valid)
        else $error("loaded result not presented");

    // no target beyond the configured count is ever signalled
    a_mask_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ((16'(result.kill_mask) >> NUM_TARGETS) == 16'd0))
        else $error("kill for nonexistent target");

    // a clock jump is only acted on after grace
    a_jump_grace: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.clock_jump) |-> !result.in_grace)
        else $error("clock jump reported inside grace");

    // no new item while a channel sweep runs
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.chk_step || cmd.jmp_step) |-> !item.ready)
        else $error("item taken during sweep");

endmodule
